>>> design/nms_pkg.sv
// ----------------------------------------------------------------------------
// nms_pkg: shared definitions for the nibble machine
// Opcode and status codes, word widths and the step limit.
// ----------------------------------------------------------------------------
package nms_pkg;

  localparam int NIB_W     = 4;
  localparam int CELLS     = 16;
  localparam int ADDR_W    = 4;
  localparam int STEP_W    = 24;
  localparam int IMAGE_W   = NIB_W * CELLS;

  localparam logic [STEP_W-1:0] STEP_MAX   = 24'hFFFFFF;
  localparam logic [STEP_W-1:0] STEP_LIMIT = 24'd16777215;

  typedef logic [NIB_W-1:0]  nib_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_HALT   = 4'h0,
    OP_INC0   = 4'h1,
    OP_DEC0   = 4'h2,
    OP_INC1   = 4'h3,
    OP_DEC1   = 4'h4,
    OP_ADD    = 4'h5,
    OP_SUB    = 4'h6,
    OP_PRINT  = 4'h7,
    OP_JNZ    = 4'h8,
    OP_JZ     = 4'h9,
    OP_LDI0   = 4'hA,
    OP_LDI1   = 4'hB,
    OP_ST0    = 4'hC,
    OP_ST1    = 4'hD,
    OP_SWP0   = 4'hE,
    OP_SWP1   = 4'hF
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_HALT  = 2'd1,
    ST_LIMIT = 2'd2
  } status_t;

endpackage

>>> design/nibble_machine_step.sv
// ----------------------------------------------------------------------------
// nibble_machine_step: one-instruction-per-beat 4-bit machine
// Two registers, a program counter and sixteen nibbles of memory in
// flip-flops; restart reloads memory from the program image.
// ----------------------------------------------------------------------------
// On each input beat, fetch, operand fetch, the indirect read for swaps
// and the update all happen in one pass of logic from the machine
// registers back into them. The machine registers double as the result
// register, so a new beat is accepted in the cycle the previous result
// is taken (in_ready = !out_valid || out_ready), giving one beat per
// cycle sustained while out_ready is held high. The program image written
// through cfg_we and cfg_data is copied into memory only on a restart beat.
module nibble_machine_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [nms_pkg::IMAGE_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       print_valid,
  output logic [nms_pkg::NIB_W-1:0]  print_value,
  output logic [1:0]                 status,
  output logic [nms_pkg::NIB_W-1:0]  acc_zero,
  output logic [nms_pkg::NIB_W-1:0]  acc_one,
  output logic [nms_pkg::ADDR_W-1:0] program_counter,
  output logic [nms_pkg::STEP_W-1:0] steps_taken
);
  import nms_pkg::*;

  logic [IMAGE_W-1:0] program_image;
  nib_t               cells [CELLS];
  nib_t               r0;
  nib_t               r1;
  addr_t              pc;
  step_t              steps;
  status_t            run_status;

  logic    accept;
  op_t     op;
  nib_t    opnd;
  nib_t    mem_rd;
  addr_t   pc_inc;
  addr_t   pc_skip;
  nib_t    r0_next;
  nib_t    r1_next;
  addr_t   pc_next;
  step_t   steps_next;
  status_t status_next;
  logic    printed;
  logic    mem_we;
  nib_t    mem_wdata;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign pc_inc  = pc + addr_t'(1);
  assign pc_skip = pc + addr_t'(2);
  assign op      = op_t'(cells[pc]);
  assign opnd    = cells[pc_inc];
  assign mem_rd  = cells[opnd];

  always_comb begin
    r0_next     = r0;
    r1_next     = r1;
    pc_next     = pc_skip;
    printed     = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = r0;
    steps_next  = (steps != STEP_MAX) ? steps + step_t'(1) : steps;
    status_next = run_status;

    unique case (op)
      OP_HALT:  pc_next = pc;
      OP_INC0: begin
        r0_next = r0 + nib_t'(1);
        pc_next = pc_inc;
      end
      OP_DEC0: begin
        r0_next = r0 - nib_t'(1);
        pc_next = pc_inc;
      end
      OP_INC1: begin
        r1_next = r1 + nib_t'(1);
        pc_next = pc_inc;
      end
      OP_DEC1: begin
        r1_next = r1 - nib_t'(1);
        pc_next = pc_inc;
      end
      OP_ADD: begin
        r0_next = r0 + r1;
        pc_next = pc_inc;
      end
      OP_SUB: begin
        r0_next = r0 - r1;
        pc_next = pc_inc;
      end
      OP_PRINT: begin
        printed = 1'b1;
        pc_next = pc_inc;
      end
      OP_JNZ:   pc_next = (r0 != '0) ? opnd : pc_skip;
      OP_JZ:    pc_next = (r0 == '0) ? opnd : pc_skip;
      OP_LDI0:  r0_next = opnd;
      OP_LDI1:  r1_next = opnd;
      OP_ST0:   mem_we  = 1'b1;
      OP_ST1: begin
        mem_we    = 1'b1;
        mem_wdata = r1;
      end
      OP_SWP0: begin
        mem_we  = 1'b1;
        r0_next = mem_rd;
      end
      OP_SWP1: begin
        mem_we    = 1'b1;
        mem_wdata = r1;
        r1_next   = mem_rd;
      end
      default: pc_next = pc;
    endcase

    // halt wins over the step limit on the same step
    if (op == OP_HALT) begin
      status_next = ST_HALT;
    end else if (steps_next >= STEP_LIMIT) begin
      status_next = ST_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_image <= '0;
      out_valid     <= 1'b0;
      print_valid   <= 1'b0;
      print_value   <= '0;
      r0            <= '0;
      r1            <= '0;
      pc            <= '0;
      steps         <= '0;
      run_status    <= ST_RUN;
      for (int i = 0; i < CELLS; i++) begin
        cells[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        program_image <= cfg_data;
      end

      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        print_valid <= 1'b0;
        print_value <= '0;
        if (restart) begin
          r0         <= '0;
          r1         <= '0;
          pc         <= '0;
          steps      <= '0;
          run_status <= ST_RUN;
          for (int i = 0; i < CELLS; i++) begin
            cells[i] <= program_image[NIB_W*i +: NIB_W];
          end
        end else if (run_status == ST_RUN) begin
          r0          <= r0_next;
          r1          <= r1_next;
          pc          <= pc_next;
          steps       <= steps_next;
          run_status  <= status_next;
          print_valid <= printed;
          print_value <= printed ? r0 : '0;
          if (mem_we) begin
            cells[opnd] <= mem_wdata;
          end
        end
      end
    end
  end

  assign status          = run_status;
  assign acc_zero        = r0;
  assign acc_one         = r1;
  assign program_counter = pc;
  assign steps_taken     = steps;

  // a restart beat leaves the cleared machine behind
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && restart |=> steps == '0 && pc == '0 && run_status == ST_RUN)
    else $error("restart did not clear the machine");

  // a frozen machine ignores execute beats
  a_frozen_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !restart && run_status != ST_RUN |=>
      $stable(pc) && $stable(steps) && $stable(r0) && $stable(r1) && !print_valid)
    else $error("frozen machine changed state");

  // halted machine sits on a halt opcode
  a_halt_on_op: assert property (@(posedge clk) disable iff (rst)
    run_status == ST_HALT |-> op == OP_HALT)
    else $error("halted with the counter off a halt cell");

  // step limit status only with the count at the limit
  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    run_status == ST_LIMIT |-> steps == STEP_LIMIT)
    else $error("step limit status with count off the limit");

endmodule

>>> bench/nms_step_checker.sv
// ----------------------------------------------------------------------------
// nms_step_checker: scoreboard for the nibble machine
// Tracks the program image, predicts one result per accepted input beat
// and compares every output beat field by field against the oldest one.
// ----------------------------------------------------------------------------
module nms_step_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [nms_pkg::IMAGE_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        restart,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        print_valid,
  input  logic [nms_pkg::NIB_W-1:0]   print_value,
  input  logic [1:0]                  status,
  input  logic [nms_pkg::NIB_W-1:0]   acc_zero,
  input  logic [nms_pkg::NIB_W-1:0]   acc_one,
  input  logic [nms_pkg::ADDR_W-1:0]  program_counter,
  input  logic [nms_pkg::STEP_W-1:0]  steps_taken,
  output int                          fail_count,
  output int                          outstanding
);
  import nms_pkg::*;

  typedef struct packed {
    logic    printed;
    nib_t    shown;
    status_t run_st;
    nib_t    r0;
    nib_t    r1;
    addr_t   pc;
    step_t   steps;
  } step_result_t;

  // machine copy
  logic [IMAGE_W-1:0] image_copy;
  nib_t               mem_cells [CELLS];
  nib_t               r0_q;
  nib_t               r1_q;
  addr_t              pc_q;
  step_t              steps_q;
  status_t            run_st_q;

  step_result_t       pending_results [$];
  step_result_t       want;
  int                 reported;

  function automatic step_result_t execute_beat(input logic reload);
    op_t          opc;
    addr_t        nxt;
    addr_t        skp;
    addr_t        opnd;
    nib_t         held;
    logic         printed;
    step_result_t res;
    printed = 1'b0;
    if (reload) begin
      for (int k = 0; k < CELLS; k++) mem_cells[k] = image_copy[NIB_W*k +: NIB_W];
      r0_q     = '0;
      r1_q     = '0;
      pc_q     = '0;
      steps_q  = '0;
      run_st_q = ST_RUN;
    end else if (run_st_q == ST_RUN) begin
      nxt  = pc_q + addr_t'(1);
      skp  = pc_q + addr_t'(2);
      opc  = op_t'(mem_cells[pc_q]);
      opnd = mem_cells[nxt];
      if (steps_q < STEP_MAX) steps_q = steps_q + step_t'(1);
      if (opc == OP_HALT) begin
        // pc stays on the halt cell; halt wins over the step limit
        run_st_q = ST_HALT;
      end else begin
        unique case (opc)
          OP_INC0:  begin r0_q = r0_q + nib_t'(1); pc_q = nxt; end
          OP_DEC0:  begin r0_q = r0_q - nib_t'(1); pc_q = nxt; end
          OP_INC1:  begin r1_q = r1_q + nib_t'(1); pc_q = nxt; end
          OP_DEC1:  begin r1_q = r1_q - nib_t'(1); pc_q = nxt; end
          OP_ADD:   begin r0_q = r0_q + r1_q; pc_q = nxt; end
          OP_SUB:   begin r0_q = r0_q - r1_q; pc_q = nxt; end
          OP_PRINT: begin printed = 1'b1; pc_q = nxt; end
          OP_JNZ:   pc_q = (r0_q != '0) ? opnd : skp;
          OP_JZ:    pc_q = (r0_q == '0) ? opnd : skp;
          OP_LDI0:  begin r0_q = opnd; pc_q = skp; end
          OP_LDI1:  begin r1_q = opnd; pc_q = skp; end
          OP_ST0:   begin mem_cells[opnd] = r0_q; pc_q = skp; end
          OP_ST1:   begin mem_cells[opnd] = r1_q; pc_q = skp; end
          OP_SWP0: begin
            held            = r0_q;
            r0_q            = mem_cells[opnd];
            mem_cells[opnd] = held;
            pc_q            = skp;
          end
          default: begin
            held            = r1_q;
            r1_q            = mem_cells[opnd];
            mem_cells[opnd] = held;
            pc_q            = skp;
          end
        endcase
        if (steps_q >= STEP_LIMIT) run_st_q = ST_LIMIT;
      end
    end
    res.printed = printed;
    res.shown   = printed ? r0_q : '0;
    res.run_st  = run_st_q;
    res.r0      = r0_q;
    res.r1      = r1_q;
    res.pc      = pc_q;
    res.steps   = steps_q;
    return res;
  endfunction

  task automatic note_failure(input string what, input logic [STEP_W-1:0] exp_v,
                              input logic [STEP_W-1:0] got_v);
    fail_count++;
    if (reported < 10) begin
      reported++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
    end
  endtask

  task automatic compare_field(input string what, input logic [STEP_W-1:0] exp_v,
                               input logic [STEP_W-1:0] got_v);
    if (exp_v !== got_v) note_failure(what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      image_copy = '0;
      for (int k = 0; k < CELLS; k++) mem_cells[k] = '0;
      r0_q       = '0;
      r1_q       = '0;
      pc_q       = '0;
      steps_q    = '0;
      run_st_q   = ST_RUN;
      pending_results.delete();
      fail_count = 0;
      reported   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          note_failure("unexpected result beat", '0, '1);
        end else begin
          want = pending_results.pop_front();
          compare_field("print_valid",     step_t'(want.printed), step_t'(print_valid));
          compare_field("print_value",     step_t'(want.shown),   step_t'(print_value));
          compare_field("status",          step_t'(want.run_st),  step_t'(status));
          compare_field("acc_zero",        step_t'(want.r0),      step_t'(acc_zero));
          compare_field("acc_one",         step_t'(want.r1),      step_t'(acc_one));
          compare_field("program_counter", step_t'(want.pc),      step_t'(program_counter));
          compare_field("steps_taken",     want.steps,            steps_taken);
        end
      end
      if (in_valid && in_ready) pending_results.push_back(execute_beat(restart));
      if (cfg_we) image_copy = cfg_data;
    end
    outstanding = pending_results.size();
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for nibble_machine_step
// Directed programs first, then random images and instruction runs with
// random gaps on both sides; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import nms_pkg::*;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [IMAGE_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               restart;
  logic               out_valid;
  logic               out_ready;
  logic               print_valid;
  logic [NIB_W-1:0]   print_value;
  logic [1:0]         status;
  logic [NIB_W-1:0]   acc_zero;
  logic [NIB_W-1:0]   acc_one;
  logic [ADDR_W-1:0]  program_counter;
  logic [STEP_W-1:0]  steps_taken;

  int fail_count;
  int outstanding;
  int beats_sent;
  bit hold_done;
  bit quiet;
  int img_kind;
  int run_len;

  always #2 clk = ~clk;

  nibble_machine_step u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .restart         (restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .print_valid     (print_valid),
    .print_value     (print_value),
    .status          (status),
    .acc_zero        (acc_zero),
    .acc_one         (acc_one),
    .program_counter (program_counter),
    .steps_taken     (steps_taken)
  );

  nms_step_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .restart         (restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .print_valid     (print_valid),
    .print_value     (print_value),
    .status          (status),
    .acc_zero        (acc_zero),
    .acc_one         (acc_one),
    .program_counter (program_counter),
    .steps_taken     (steps_taken),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    else if (roll < 94) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // random program, opcode zero kept rare so runs get past the first cells
  function automatic logic [IMAGE_W-1:0] random_program();
    logic [IMAGE_W-1:0] img;
    for (int k = 0; k < CELLS; k++)
      img[NIB_W*k +: NIB_W] = ($urandom_range(0, 24) == 0) ? nib_t'(0)
                                                           : nib_t'($urandom_range(1, 15));
    return img;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic reload, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= reload;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_image(input logic [IMAGE_W-1:0] img);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= img;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    restart    = 1'b0;
    beats_sent = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // power-on: memory is all zeros, so the first step halts, then stays frozen
    send_beat(1'b0, 0);
    send_beat(1'b0, 1);

    write_image('0);
    send_beat(1'b1, 0);
    send_beat(1'b0, 0);

    // both jump outcomes, print, add/sub, swap through memory, ends on halt
    write_image(64'hDC08_0E72_0865_690A);
    send_beat(1'b1, 0);
    repeat (14) send_beat(1'b0, pick_gap());

    write_image('1);
    send_beat(1'b1, 0);
    repeat (3) send_beat(1'b0, 0);

    while (beats_sent < 1700) begin
      img_kind = $urandom_range(0, 19);
      case (img_kind)
        0:       drain();
        1:       write_image('0);
        2:       write_image('1);
        3:       write_image({$urandom, $urandom});
        4:       write_image(64'h5A5A_A5A5_3C3C_C3C3);
        default: write_image(random_program());
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      // a few runs continue from the old memory contents
      if ($urandom_range(0, 7) != 0) send_beat(1'b1, quiet ? 0 : pick_gap());
      run_len = $urandom_range(4, 40);
      repeat (run_len) send_beat($urandom_range(0, 24) == 0, quiet ? 0 : pick_gap());
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("** nibble_machine_step: PASSED **");
    else
      $display("** nibble_machine_step: FAILED **");
    $finish;
  end

  // result side: random stalls, calm stretches, one long hold-off
  initial begin
    int stall;
    int calm;
    out_ready = 1'b0;
    hold_done = 1'b0;
    calm      = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (!hold_done && beats_sent >= 600 && in_valid) begin
        hold_done = 1'b1;
        stall     = 150;
      end else if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = pick_gap();
        if ($urandom_range(0, 49) == 0) calm = $urandom_range(30, 120);
      end
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #4000000;
    $display("** nibble_machine_step: FAILED **");
    $finish;
  end

endmodule

>>> nibble_machine_step.f
design/nms_pkg.sv
design/nibble_machine_step.sv
bench/nms_step_checker.sv
bench/tb_top.sv
